// ----- design/cre_pkg.sv -----
package cre_pkg;

	localparam int NSYM        = 256;
	localparam int NMODELS     = 260;
	localparam int MEM_DEPTH   = NMODELS * NSYM;
	localparam int ADDR_W      = 17;
	localparam int MODEL_W     = 9;
	localparam int TOT_W       = 17;
	localparam int TOTAL_LIMIT = 65536;
	localparam int NUM_HI_MOD  = 4;
	localparam int MAX_RES     = 5;
	localparam int FIN_SHIFTS  = 5;
	localparam int CQ_DEPTH    = 2;
	localparam int CQ_AW       = 1;
	localparam int RQ_DEPTH    = 8;
	localparam int RQ_AW       = 3;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] FILL_ZERO = 8'h00;
	localparam logic [7:0] FILL_ONES = 8'hFF;

	localparam logic [2:0] CTX_NONE = 3'd0;
	localparam logic [2:0] CTX_CLS4 = 3'd1;
	localparam logic [2:0] CTX_FULL = 3'd2;
	localparam logic [2:0] CTX_HI   = 3'd3;

	typedef struct packed {
		logic       op;
		logic [1:0] hm;
		logic [7:0] lm;
		logic [7:0] hi;
		logic [7:0] lo;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  coded_byte;
		logic [31:0] fill_count;
		logic [7:0]  fill_byte;
		logic        last_result;
	} result_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	function automatic logic [1:0] class4(input logic [7:0] h);
		logic [1:0] c;
		if (h == 8'd0) c = 2'd0;
		else if (h <= 8'd2) c = 2'd1;
		else if (h <= 8'd8) c = 2'd2;
		else c = 2'd3;
		return c;
	endfunction

endpackage

// ----- design/context_range_encoder_unit.sv -----
// Sequencing: an encode beat holds the back end for two byte codings. Each one divides the range
//   by the model total, walks the Fenwick tree for the prefix, multiplies and applies, then
//   renormalizes and walks the tree again to update it. A byte whose model hits the count limit
//   swaps its update walk for a halving pass over 256 counts.
// Throughput: one beat at a time in the back end; the two-entry command queue takes new beats.
// Reset: arst_n clears control at once, then a pass fills the model memories;
//   full stays high during it. A finish beat (five shifts) triggers the same pass.
module context_range_encoder_unit import cre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input side
	input  logic        push,
	output logic        full,
	input  logic        opcode,
	input  logic [15:0] symbol,
	// result side
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  coded_byte,
	output logic [31:0] fill_count,
	output logic [7:0]  fill_byte,
	output logic        last_result,
	// context_mode register
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data
);

	// front -> back command queue
	cmd_t           cmd;
	logic           cmd_valid, cmd_pop;
	back_stat_t     stat;
	// back -> result queue
	logic           rq_push;
	result_t        rq_wdata, rq_rdata;
	logic [RQ_AW:0] rq_level;

	// front: accepts beats, holds context_mode and the previous high byte,
	// picks the high and low models
	cre_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.symbol      (symbol),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.stat        (stat),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd)
	);

	// back: range coder sequencer, model memories, carry/cache byte stage
	cre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.rq_level  (rq_level),
		.rq_push   (rq_push),
		.rq_data   (rq_wdata),
		.stat      (stat)
	);

	// result queue: back only starts a beat when five slots are free
	cre_rq u_rq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rq_push),
		.wr_data (rq_wdata),
		.pop     (pop),
		.empty   (empty),
		.rd_data (rq_rdata),
		.level   (rq_level)
	);

	assign coded_byte  = rq_rdata.coded_byte;
	assign fill_count  = rq_rdata.fill_count;
	assign fill_byte   = rq_rdata.fill_byte;
	assign last_result = rq_rdata.last_result;

endmodule

// ----- design/cre_front.sv -----
module cre_front import cre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       opcode,
	input  logic [15:0] symbol,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  back_stat_t stat,
	output logic       cmd_valid,
	input  logic       cmd_pop,
	output cmd_t       cmd
);

	cmd_t             cq_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CQ_AW:0]   level_q;
	logic [2:0]       context_mode_q;
	logic [7:0]       prev_high_q;
	logic             accept;
	logic             hctx;
	logic [2:0]       basec;
	cmd_t             new_cmd;

	assign full      = (level_q == (CQ_AW+1)'(CQ_DEPTH)) || stat.clearing;
	assign accept    = push && !full;
	assign cmd_valid = (level_q != '0);
	assign cmd       = cq_q[rd_ptr_q];

	// classify: pick the two models for this beat
	always_comb begin
		hctx  = (context_mode_q >= CTX_HI);
		basec = hctx ? (context_mode_q - CTX_HI) : context_mode_q;
		new_cmd.op = opcode;
		new_cmd.hi = symbol[15:8];
		new_cmd.lo = symbol[7:0];
		new_cmd.hm = hctx ? class4(prev_high_q) : 2'd0;
		if (basec == CTX_CLS4) new_cmd.lm = {6'd0, class4(symbol[15:8])};
		else if (basec == CTX_FULL) new_cmd.lm = symbol[15:8];
		else new_cmd.lm = 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q       <= '0;
			rd_ptr_q       <= '0;
			level_q        <= '0;
			context_mode_q <= CTX_NONE;
			prev_high_q    <= 8'd0;
		end else begin
			if (cfg_wr_en) context_mode_q <= cfg_wr_data;
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				if (opcode == OP_FINISH) prev_high_q <= 8'd0;
				else prev_high_q <= symbol[15:8];
			end
			if (cmd_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			level_q <= level_q + (CQ_AW+1)'(accept) - (CQ_AW+1)'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) cq_q[wr_ptr_q] <= new_cmd;
	end

endmodule

// ----- design/cre_div.sv -----
module cre_div import cre_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      dividend,
	input  logic [TOT_W-1:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	logic [31:0]      dvd_q;
	logic [TOT_W-1:0] dvs_q;
	logic [TOT_W-1:0] rem_q;
	logic [4:0]       cnt_q;
	logic             busy_q, done_q;
	logic [TOT_W:0]   trial;
	logic             qbit;

	// restoring divide, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, dvd_q[31]};
		qbit  = (trial >= {1'b0, dvs_q});
	end

	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? TOT_W'(trial - {1'b0, dvs_q}) : trial[TOT_W-1:0];
			dvd_q <= {dvd_q[30:0], qbit};
		end
	end

endmodule

// ----- design/cre_rq.sv -----
module cre_rq import cre_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  result_t        wr_data,
	input  logic           pop,
	output logic           empty,
	output result_t        rd_data,
	output logic [RQ_AW:0] level
);

	result_t          rq_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [RQ_AW:0]   level_q;
	logic             do_pop;

	assign empty   = (level_q == '0);
	assign do_pop  = pop && !empty;
	assign rd_data = rq_q[rd_ptr_q];
	assign level   = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			level_q <= level_q + (RQ_AW+1)'(wr_en) - (RQ_AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) rq_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ----- design/cre_back.sv -----
module cre_back import cre_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	input  cmd_t           cmd,
	input  logic [RQ_AW:0] rq_level,
	output logic           rq_push,
	output result_t        rq_data,
	output back_stat_t     stat
);

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_FIN, ST_TOT_RD, ST_TOT_WAIT, ST_DIV, ST_PFX_RD, ST_PFX_ACC,
		ST_CNT_RD, ST_CNT_WAIT, ST_MUL, ST_APPLY, ST_NORM, ST_UPD, ST_TA_RD, ST_TA_WR,
		ST_HV_RD, ST_HV_WR, ST_END_BYTE, ST_END_ITEM
	} state_t;

	state_t state_q;

	// model storage
	logic [15:0]      cnt_mem  [MEM_DEPTH];
	logic [15:0]      tree_mem [MEM_DEPTH];
	logic [TOT_W-1:0] tot_mem  [NMODELS];
	logic [15:0]      cnt_rd_q, tree_rd_q;
	logic [TOT_W-1:0] tot_rd_q;

	logic              cnt_we, tree_we, tot_we;
	logic [ADDR_W-1:0] cnt_raddr, cnt_waddr, tree_raddr, tree_waddr;
	logic [15:0]       cnt_wdata, tree_wdata;
	logic [MODEL_W-1:0] tot_raddr, tot_waddr;
	logic [TOT_W-1:0]  tot_wdata;

	cmd_t               cmd_q;
	logic               byte_sel_q;
	logic [MODEL_W-1:0] model_q;
	logic [7:0]         sym_q;
	logic [TOT_W-1:0]   tot_q;
	logic [31:0]        r_q;
	logic [TOT_W-1:0]   cum_q;
	logic [8:0]         idx_q;
	logic [15:0]        cnt_val_q;
	logic [31:0]        prod_cum_q, prod_cnt_q;
	logic [32:0]        low_q;
	logic [31:0]        range_q;
	logic [7:0]         cache_q;
	logic [31:0]        pend_q;
	logic [2:0]         res_n_q;
	logic [2:0]         fin_n_q;
	result_t            held_q;
	logic               held_v_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [TOT_W-1:0]   psum_q;
	logic [TOT_W-1:0]   acc_q [10];

	// divider
	logic             div_start, div_done;
	logic [TOT_W-1:0] div_dvs;
	logic [31:0]      div_quot;

	cre_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (range_q),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quot)
	);

	// byte shift-out
	logic      do_shift, carry, flush, emit;
	logic [7:0] top;
	result_t   new_res;
	logic      norm_go;

	// walks and halving pass
	logic [8:0]       idx_m1, pfx_lb, pfx_next;
	logic [9:0]       ta_next;
	logic [8:0]       clr_v, clr_lb;
	logic [16:0]      half;
	logic [TOT_W-1:0] hv_p;
	logic [8:0]       hv_i1;
	logic [3:0]       hv_tz;
	logic [TOT_W:0]   tot_inc;
	logic [48:0]      mul_cum;
	logic [47:0]      mul_cnt;
	logic             start_ok;

	always_comb begin
		carry    = low_q[32];
		top      = low_q[31:24];
		flush    = (top != FILL_ONES) || carry;
		norm_go  = (range_q != 32'd0) && (range_q < 32'h0100_0000);
		do_shift = (state_q == ST_FIN) || ((state_q == ST_NORM) && norm_go);
		emit     = do_shift && flush && (res_n_q < 3'(MAX_RES));
		new_res.coded_byte  = cache_q + {7'd0, carry};
		new_res.fill_count  = pend_q;
		new_res.fill_byte   = carry ? FILL_ZERO : FILL_ONES;
		new_res.last_result = 1'b0;

		idx_m1   = idx_q - 9'd1;
		pfx_lb   = idx_q & (~idx_q + 9'd1);
		pfx_next = idx_q - pfx_lb;
		ta_next  = {1'b0, idx_q} + {1'b0, pfx_lb};

		clr_v  = {1'b0, clr_q[7:0]} + 9'd1;
		clr_lb = clr_v & (~clr_v + 9'd1);

		half  = ({1'b0, cnt_rd_q} + 17'd1) >> 1;
		hv_p  = psum_q + half;
		hv_i1 = idx_q + 9'd1;
		hv_tz = 4'd8;
		for (int b = 7; b >= 0; b--) begin
			if (hv_i1[b]) hv_tz = 4'(b);
		end

		tot_inc = {1'b0, tot_q} + 18'd1;
		mul_cum = 49'(cum_q) * 49'(r_q);
		mul_cnt = 48'(cnt_val_q) * 48'(r_q);
		start_ok = cmd_valid && !held_v_q && (rq_level <= (RQ_AW+1)'(RQ_DEPTH - MAX_RES));
	end

	assign cmd_pop        = (state_q == ST_IDLE) && start_ok;
	assign stat.clearing  = (state_q == ST_CLR);
	assign div_start      = (state_q == ST_TOT_WAIT);
	assign div_dvs        = (tot_rd_q == '0) ? TOT_W'(1) : tot_rd_q;

	// memory ports and result pushes
	always_comb begin
		cnt_we     = 1'b0;
		tree_we    = 1'b0;
		tot_we     = 1'b0;
		cnt_raddr  = {model_q, sym_q};
		tree_raddr = {model_q, idx_m1[7:0]};
		tot_raddr  = model_q;
		cnt_waddr  = {model_q, sym_q};
		tree_waddr = {model_q, idx_m1[7:0]};
		tot_waddr  = model_q;
		cnt_wdata  = cnt_val_q + 16'd1;
		tree_wdata = tree_rd_q + 16'd1;
		tot_wdata  = tot_inc[TOT_W-1:0];
		rq_push    = 1'b0;
		rq_data    = held_q;
		case (state_q)
			ST_CLR: begin
				cnt_we     = 1'b1;
				tree_we    = 1'b1;
				cnt_waddr  = clr_q;
				tree_waddr = clr_q;
				cnt_wdata  = 16'd1;
				tree_wdata = {7'd0, clr_lb};
				tot_we     = (clr_q < ADDR_W'(NMODELS));
				tot_waddr  = clr_q[MODEL_W-1:0];
				tot_wdata  = TOT_W'(NSYM);
			end
			ST_UPD: begin
				cnt_we = 1'b1;
				tot_we = (tot_inc < (TOT_W+1)'(TOTAL_LIMIT));
			end
			ST_TA_WR: tree_we = 1'b1;
			ST_HV_RD: cnt_raddr = {model_q, idx_q[7:0]};
			ST_HV_WR: begin
				cnt_we     = 1'b1;
				tree_we    = 1'b1;
				cnt_waddr  = {model_q, idx_q[7:0]};
				tree_waddr = {model_q, idx_q[7:0]};
				cnt_wdata  = half[15:0];
				tree_wdata = 16'(hv_p - acc_q[hv_tz + 4'd1]);
				tot_we     = (idx_q == 9'd255);
				tot_wdata  = hv_p;
			end
			ST_END_ITEM: begin
				rq_push = held_v_q;
				rq_data.last_result = 1'b1;
			end
			default: begin
			end
		endcase
		if (emit && held_v_q) rq_push = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd_q <= cnt_mem[cnt_raddr];
		if (tree_we) tree_mem[tree_waddr] <= tree_wdata;
		tree_rd_q <= tree_mem[tree_raddr];
		if (tot_we) tot_mem[tot_waddr] <= tot_wdata;
		tot_rd_q <= tot_mem[tot_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			low_q    <= '0;
			range_q  <= 32'hFFFF_FFFF;
			cache_q  <= 8'd0;
			pend_q   <= 32'd0;
			held_v_q <= 1'b0;
			res_n_q  <= '0;
			fin_n_q  <= '0;
		end else begin
			if (do_shift) begin
				if (flush) begin
					pend_q  <= 32'd0;
					cache_q <= top;
				end else begin
					pend_q <= pend_q + 32'd1;
				end
				low_q <= {1'b0, low_q[23:0], 8'h00};
				if (emit) begin
					held_q   <= new_res;
					held_v_q <= 1'b1;
					res_n_q  <= res_n_q + 3'd1;
				end
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(MEM_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start_ok) begin
						cmd_q   <= cmd;
						res_n_q <= '0;
						fin_n_q <= '0;
						if (cmd.op == OP_FINISH) begin
							state_q <= ST_FIN;
						end else begin
							byte_sel_q <= 1'b0;
							model_q    <= {7'd0, cmd.hm};
							sym_q      <= cmd.hi;
							state_q    <= ST_TOT_RD;
						end
					end
				end
				ST_FIN: begin
					fin_n_q <= fin_n_q + 3'd1;
					if (fin_n_q == 3'(FIN_SHIFTS - 1)) state_q <= ST_END_ITEM;
				end
				ST_TOT_RD: state_q <= ST_TOT_WAIT;
				ST_TOT_WAIT: begin
					tot_q   <= tot_rd_q;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						r_q   <= div_quot;
						cum_q <= '0;
						idx_q <= {1'b0, sym_q};
						state_q <= (sym_q == 8'd0) ? ST_CNT_RD : ST_PFX_RD;
					end
				end
				ST_PFX_RD: state_q <= ST_PFX_ACC;
				ST_PFX_ACC: begin
					cum_q <= cum_q + {1'b0, tree_rd_q};
					idx_q <= pfx_next;
					state_q <= (pfx_next == 9'd0) ? ST_CNT_RD : ST_PFX_RD;
				end
				ST_CNT_RD: state_q <= ST_CNT_WAIT;
				ST_CNT_WAIT: begin
					cnt_val_q <= cnt_rd_q;
					state_q   <= ST_MUL;
				end
				ST_MUL: begin
					prod_cum_q <= mul_cum[31:0];
					prod_cnt_q <= mul_cnt[31:0];
					state_q    <= ST_APPLY;
				end
				ST_APPLY: begin
					low_q <= low_q + {1'b0, prod_cum_q};
					if (sym_q != 8'hFF) range_q <= prod_cnt_q;
					else range_q <= range_q - prod_cum_q;
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (norm_go) range_q <= {range_q[23:0], 8'h00};
					else state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (tot_inc >= (TOT_W+1)'(TOTAL_LIMIT)) begin
						idx_q  <= '0;
						psum_q <= '0;
						for (int k = 0; k < 10; k++) acc_q[k] <= '0;
						state_q <= ST_HV_RD;
					end else begin
						idx_q   <= {1'b0, sym_q} + 9'd1;
						state_q <= ST_TA_RD;
					end
				end
				ST_TA_RD: state_q <= ST_TA_WR;
				ST_TA_WR: begin
					idx_q <= ta_next[8:0];
					state_q <= (ta_next > 10'(NSYM)) ? ST_END_BYTE : ST_TA_RD;
				end
				ST_HV_RD: state_q <= ST_HV_WR;
				ST_HV_WR: begin
					psum_q <= hv_p;
					for (int k = 0; k < 9; k++) begin
						if (4'(k) <= hv_tz) acc_q[k] <= hv_p;
					end
					idx_q <= hv_i1;
					state_q <= (idx_q == 9'd255) ? ST_END_BYTE : ST_HV_RD;
				end
				ST_END_BYTE: begin
					if (!byte_sel_q) begin
						byte_sel_q <= 1'b1;
						model_q    <= MODEL_W'(NUM_HI_MOD) + {1'b0, cmd_q.lm};
						sym_q      <= cmd_q.lo;
						state_q    <= ST_TOT_RD;
					end else begin
						state_q <= ST_END_ITEM;
					end
				end
				ST_END_ITEM: begin
					held_v_q <= 1'b0;
					if (cmd_q.op == OP_FINISH) begin
						low_q   <= '0;
						range_q <= 32'hFFFF_FFFF;
						cache_q <= 8'd0;
						pend_q  <= 32'd0;
						clr_q   <= '0;
						state_q <= ST_CLR;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/cre_checker.sv -----
module cre_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  coded_byte,
	input logic [31:0] fill_count,
	input logic [7:0]  fill_byte,
	input logic        last_result
);

	// fill value is only ever zero or all ones
	a_fill_val: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (fill_byte == 8'h00 || fill_byte == 8'hFF))
		else $error("fill_byte not 00/FF");

	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(coded_byte) && $stable(fill_count)
		&& $stable(fill_byte) && $stable(last_result)))
		else $error("result changed while waiting");

	// model fill pass blocks input right after reset
	a_rst_full: assert property (@(posedge clk) $rose(arst_n) |-> full)
		else $error("input open during fill pass");

	// nothing to deliver right after reset
	a_rst_empty: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result queue not empty after reset");

endmodule

bind context_range_encoder_unit cre_checker u_cre_checker (.*);

// ----- tb/cre_scoreboard.sv -----
module cre_scoreboard import cre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        opcode,
	input  logic [15:0] symbol,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  coded_byte,
	input  logic [31:0] fill_count,
	input  logic [7:0]  fill_byte,
	input  logic        last_result,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	output int          fail_count,
	output int          flushes_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [2:0]      mode_sel;
	longint unsigned low_q;
	logic [31:0]     range_q;
	logic [7:0]      cache_q;
	logic [31:0]     run_q;
	logic [7:0]      prev_hi;
	logic [15:0]     freq [MEM_DEPTH];
	logic [15:0]     fen [MEM_DEPTH];
	int unsigned     tot [NMODELS];
	result_t         flush_q [$];
	int              beat_flushes;

	function automatic int unsigned lowbit(input int unsigned i);
		return i & (~i + 1);
	endfunction

	task automatic fen_add(input int unsigned base, input int unsigned s, input int unsigned d);
		int unsigned i;
		for (i = s + 1; i <= NSYM; i += lowbit(i))
			fen[base + i - 1] = fen[base + i - 1] + d[15:0];
	endtask

	function automatic int unsigned fen_prefix(input int unsigned base, input int unsigned s);
		int unsigned acc, i;
		acc = 0;
		for (i = s; i > 0; i -= lowbit(i))
			acc += fen[base + i - 1];
		return acc;
	endfunction

	task automatic fen_rebuild(input int unsigned m);
		int unsigned i;
		for (i = 0; i < NSYM; i++) fen[m*NSYM + i] = '0;
		for (i = 0; i < NSYM; i++) fen_add(m*NSYM, i, freq[m*NSYM + i]);
	endtask

	task automatic clear_state();
		int unsigned i;
		low_q   = 0;
		range_q = 32'hFFFF_FFFF;
		cache_q = '0;
		run_q   = '0;
		prev_hi = '0;
		// all-ones counts: each Fenwick node holds its own span length
		for (i = 0; i < MEM_DEPTH; i++) begin
			freq[i] = 16'd1;
			fen[i]  = 16'(lowbit(i % NSYM + 1));
		end
		for (i = 0; i < NMODELS; i++) tot[i] = NSYM;
	endtask

	task automatic add_flush(input logic [7:0] b, input logic [31:0] n, input logic [7:0] f);
		result_t r;
		if (beat_flushes >= MAX_RES) return;
		r.coded_byte  = b;
		r.fill_count  = n;
		r.fill_byte   = f;
		r.last_result = 1'b0;
		flush_q.insert(flush_q.size(), r);
		beat_flushes++;
	endtask

	task automatic shift_byte();
		logic       carry;
		logic [7:0] top;
		carry = low_q[32];
		top   = low_q[31:24];
		if (top != 8'hFF || carry) begin
			add_flush(cache_q + {7'd0, carry}, run_q, carry ? FILL_ZERO : FILL_ONES);
			run_q   = '0;
			cache_q = top;
		end else begin
			run_q = run_q + 1;
		end
		low_q = (low_q << 8) & 64'hFFFF_FFFF;
	endtask

	task automatic bump_model(input int unsigned m, input int unsigned s);
		int unsigned base, i, t;
		base = m * NSYM;
		freq[base + s] = freq[base + s] + 16'd1;
		tot[m]++;
		if (tot[m] >= TOTAL_LIMIT) begin
			t = 0;
			for (i = 0; i < NSYM; i++) begin
				freq[base + i] = 16'((32'(freq[base + i]) + 1) >> 1);
				t += freq[base + i];
			end
			tot[m] = t;
			fen_rebuild(m);
		end else begin
			fen_add(base, s, 1);
		end
	endtask

	task automatic code_one(input int unsigned m, input int unsigned s);
		int unsigned base, t, step, cum;
		base = m * NSYM;
		t = (tot[m] == 0) ? 1 : tot[m];
		step = range_q / t;
		cum = fen_prefix(base, s);
		low_q += longint'(cum) * longint'(step);
		if (s < 255) range_q = freq[base + s] * step;
		else range_q = range_q - cum * step;
		while (range_q != 0 && range_q < 32'h0100_0000) begin
			range_q = range_q << 8;
			shift_byte();
		end
		bump_model(m, s);
	endtask

	task automatic predict_beat(input logic op, input logic [15:0] sym);
		logic [2:0]  sel;
		int unsigned hm, lm;
		beat_flushes = 0;
		if (op == OP_FINISH) begin
			repeat (FIN_SHIFTS) shift_byte();
			clear_state();
		end else begin
			sel = (mode_sel >= CTX_HI) ? mode_sel - CTX_HI : mode_sel;
			hm  = (mode_sel >= CTX_HI) ? class4(prev_hi) : 0;
			if (sel == CTX_CLS4) lm = class4(sym[15:8]);
			else if (sel == CTX_FULL) lm = sym[15:8];
			else lm = 0;
			code_one(hm, sym[15:8]);
			code_one(NUM_HI_MOD + lm, sym[7:0]);
			prev_hi = sym[15:8];
		end
		if (beat_flushes > 0) flush_q[$].last_result = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			mode_sel     = CTX_NONE;
			fail_count   = 0;
			flush_q.delete();
			flushes_owed = 0;
			clear_state();
		end else begin
			if (cfg_wr_en) mode_sel = cfg_wr_data;
			if (!empty && pop) begin
				if (flush_q.size() == 0) begin
					$display("%t: unexpected flush %h/%0d/%h/%b", $time, coded_byte,
						fill_count, fill_byte, last_result);
					fail_count++;
				end else begin
					want = flush_q.pop_front();
					if (want != {coded_byte, fill_count, fill_byte, last_result}) begin
						$display("%t: flush mismatch exp %h/%0d/%h/%b got %h/%0d/%h/%b",
							$time, want.coded_byte, want.fill_count, want.fill_byte,
							want.last_result, coded_byte, fill_count, fill_byte, last_result);
						fail_count++;
					end
				end
			end
			if (push && !full) predict_beat(opcode, symbol);
			flushes_owed = flush_q.size();
		end
	end

endmodule

// ----- tb/tb_context_range_encoder_unit.sv -----
module tb_context_range_encoder_unit;
	import cre_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        opcode = OP_ENCODE;
	logic [15:0] symbol = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  coded_byte;
	logic [31:0] fill_count;
	logic [7:0]  fill_byte;
	logic        last_result;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_wr_data = CTX_NONE;
	int          fail_count;
	int          flushes_owed;
	int          idle_cycles = 0;
	int          finishes_left = 4;

	// a finish or reset starts a full memory fill pass; allow that plus slack
	localparam int WATCHDOG = 250000;
	// back end may still chew on up to three beats that make no flush
	localparam int SETTLE   = 4000;

	always #10 clk = ~clk;

	context_range_encoder_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .opcode(opcode), .symbol(symbol),
		.empty(empty), .pop(pop),
		.coded_byte(coded_byte), .fill_count(fill_count), .fill_byte(fill_byte),
		.last_result(last_result),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	cre_scoreboard u_chk (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .opcode(opcode), .symbol(symbol),
		.empty(empty), .pop(pop),
		.coded_byte(coded_byte), .fill_count(fill_count), .fill_byte(fill_byte),
		.last_result(last_result),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count), .flushes_owed(flushes_owed)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// watchdog: a stretch with no beat on either side that reaches the WATCHDOG limit is a hang
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side: random back-pressure, with calm stretches of pop held high
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 7) == 0) begin
				pop = ~pop;
				hold = pop ? $urandom_range(20, 200) : pick_gap();
			end
		end
	end

	task automatic send(input logic op, input logic [15:0] sym);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push   = 1'b1;
		opcode = op;
		symbol = sym;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	// mode is changed only with the block drained and the back end quiet
	task automatic set_mode(input logic [2:0] m);
		push = 1'b0;
		@(negedge clk);
		while (flushes_owed != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		while (full) @(negedge clk);
		// beats queued behind a finish run after its fill pass
		repeat (SETTLE) @(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = m;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	task automatic random_phase(input int n);
		logic [15:0] s;
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: s = {8'(0), 8'($urandom)};
				1: s = {8'($urandom_range(1, 9)), 8'($urandom)};
				2: s = {8'hFF, 8'($urandom)};
				3: s = {8'($urandom), 8'hFF};
				default: s = 16'($urandom);
			endcase
			if (finishes_left > 0 && $urandom_range(0, 89) == 0) begin
				finishes_left--;
				send(OP_FINISH, 16'($urandom));
			end else begin
				send(OP_ENCODE, s);
			end
		end
	endtask

	initial begin
		logic [2:0] modes [8];
		modes = '{CTX_HI + 3'd2, CTX_CLS4, CTX_FULL, CTX_HI, CTX_HI + 3'd1,
			3'd6, 3'd7, CTX_NONE};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, context class edges, a finish with the default mode
		send(OP_ENCODE, 16'h0000);
		send(OP_ENCODE, 16'hFFFF);
		send(OP_ENCODE, 16'h00FF);
		send(OP_ENCODE, 16'hFF00);
		send(OP_FINISH, 16'h0000);
		set_mode(CTX_HI + 3'd1);
		send(OP_ENCODE, 16'h0000);
		send(OP_ENCODE, 16'h01FF);
		send(OP_ENCODE, 16'h0201);
		send(OP_ENCODE, 16'h0355);
		send(OP_ENCODE, 16'h08AA);
		send(OP_ENCODE, 16'h0900);
		send(OP_ENCODE, 16'hFFFE);
		send(OP_ENCODE, 16'h0000);
		// mode seven: high context with an unlisted base mode, so the low model index falls back to zero
		set_mode(3'd7);
		send(OP_ENCODE, 16'h7F80);
		send(OP_ENCODE, 16'h8001);
		send(OP_FINISH, 16'hFFFF);
		send(OP_ENCODE, 16'hFFFF);

		foreach (modes[i]) begin
			set_mode(modes[i]);
			random_phase(49);
		end

		push = 1'b0;
		while (flushes_owed != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
